// ===== src/swv_pkg.sv =====
package swv_pkg;

    // sizing of the window and the sample words
    localparam int WINDOW      = 10;
    localparam int SAMPLE_BITS = 16;
    localparam int CHANNELS    = 3;

    // fixed port widths
    localparam int IN_W      = 16;
    localparam int VAR_W     = 31;
    localparam int FILL_W    = 4;
    localparam int COUNT_MAX = 15;

    // derived widths
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
    localparam int SQ_W   = 2 * SAMPLE_BITS - 1 + $clog2(WINDOW);
    localparam int NUM_W  = CNT_W + SQ_W;
    localparam int SQR_W  = 2 * SUM_W;
    localparam int PROD_W = (NUM_W > SQR_W) ? NUM_W : SQR_W;
    localparam int DSOR_W = 2 * CNT_W;
    localparam int DCNT_W = $clog2(PROD_W + 1);
    localparam int QUO_W  = (PROD_W > VAR_W) ? PROD_W : VAR_W + 1;
    localparam int EXT_W  = (SAMPLE_BITS > IN_W) ? SAMPLE_BITS : IN_W;

    localparam logic [VAR_W-1:0] VAR_MAX = '1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SQUARE,
        S_SUMSQ,
        S_PROD,
        S_START,
        S_DIV
    } state_t;

    // sequencing strobes from the controller to every lane
    typedef struct packed
    {
        logic              accept;
        logic              evict;
        logic              square;
        logic              sumsq;
        logic              prod;
        logic              start;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  count;
    } lane_ctl_t;

    // lane status back to the controller
    typedef struct packed
    {
        logic done;
    } lane_sts_t;

    // take the low SAMPLE_BITS of a field as a signed sample
    function automatic sample_t sext(input logic [IN_W-1:0] raw);
        logic [EXT_W-1:0] t;
        t = EXT_W'(raw);
        return sample_t'(t[SAMPLE_BITS-1:0]);
    endfunction

endpackage

// ===== src/sliding_window_variance_3ch_top.sv =====
// Three-channel sliding-window variance. Each accepted word carries one signed sample
// per channel; each result word gives the population variance of every channel over
// the last WINDOW samples (fewer while the window fills), truncated and clipped to
// 31 bits, plus the number of samples held. One word is in flight at a time; each lane
// divides by n^2 with a restoring divider that gives one quotient bit per cycle. The
// result sits in an output register, so the next word is taken while it waits; a
// result still waiting holds the following one at its last divide step.
module sliding_window_variance_3ch_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [swv_pkg::IN_W-1:0]   sample_x,
    input  logic signed [swv_pkg::IN_W-1:0]   sample_y,
    input  logic signed [swv_pkg::IN_W-1:0]   sample_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [swv_pkg::VAR_W-1:0]         variance_x,
    output logic [swv_pkg::VAR_W-1:0]         variance_y,
    output logic [swv_pkg::VAR_W-1:0]         variance_z,
    output logic [swv_pkg::FILL_W-1:0]        fill_count
);

    swv_pkg::state_t            state_reg;
    swv_pkg::state_t            state_next;
    swv_pkg::lane_ctl_t         ctl;
    swv_pkg::lane_sts_t         lane_sts    [swv_pkg::CHANNELS];
    logic [swv_pkg::IN_W-1:0]   lane_sample [swv_pkg::CHANNELS];
    logic [swv_pkg::VAR_W-1:0]  lane_var    [swv_pkg::CHANNELS];

    logic [swv_pkg::SLOT_W-1:0] slot_reg;
    logic [swv_pkg::CNT_W-1:0]  held_reg;
    logic                       evict_reg;
    logic                       accept;
    logic                       all_done;
    logic                       out_free;
    logic                       out_load;
    logic                       out_valid_reg;
    logic [swv_pkg::VAR_W-1:0]  var_reg [swv_pkg::CHANNELS];
    logic [swv_pkg::FILL_W-1:0] fill_reg;
    logic [swv_pkg::FILL_W-1:0] fill_val;

    assign lane_sample[0] = sample_x;
    assign lane_sample[1] = sample_y;
    assign lane_sample[2] = sample_z;

    // one lane per channel
    for (genvar c = 0; c < swv_pkg::CHANNELS; c++)
    begin : g_lane
        swv_lane u_lane
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .sample_in (lane_sample[c]),
            .sts       (lane_sts[c]),
            .variance  (lane_var[c])
        );
    end

    // merge lane status
    always_comb
    begin
        all_done = 1'b1;
        for (int c = 0; c < swv_pkg::CHANNELS; c++)
        begin
            all_done = all_done & lane_sts[c].done;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign accept   = in_valid && (state_reg == swv_pkg::S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            swv_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = swv_pkg::S_SQUARE;
                end
            end
            swv_pkg::S_SQUARE: state_next = swv_pkg::S_SUMSQ;
            swv_pkg::S_SUMSQ:  state_next = swv_pkg::S_PROD;
            swv_pkg::S_PROD:   state_next = swv_pkg::S_START;
            swv_pkg::S_START:  state_next = swv_pkg::S_DIV;
            swv_pkg::S_DIV:
            begin
                if (all_done && out_free)
                begin
                    state_next = swv_pkg::S_IDLE;
                end
            end
            default: state_next = swv_pkg::S_IDLE;
        endcase
    end

    // controller outputs
    always_comb
    begin
        in_stall   = 1'b1;
        out_load   = 1'b0;
        ctl.accept = 1'b0;
        ctl.square = 1'b0;
        ctl.sumsq  = 1'b0;
        ctl.prod   = 1'b0;
        ctl.start  = 1'b0;
        ctl.evict  = evict_reg;
        ctl.slot   = slot_reg;
        ctl.count  = held_reg;
        case (state_reg)
            swv_pkg::S_IDLE:
            begin
                in_stall   = 1'b0;
                ctl.accept = in_valid;
            end
            swv_pkg::S_SQUARE: ctl.square = 1'b1;
            swv_pkg::S_SUMSQ:  ctl.sumsq  = 1'b1;
            swv_pkg::S_PROD:   ctl.prod   = 1'b1;
            swv_pkg::S_START:  ctl.start  = 1'b1;
            swv_pkg::S_DIV:    out_load   = all_done && out_free;
            default:           in_stall   = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swv_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // write slot, fill count and eviction flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            held_reg  <= '0;
            evict_reg <= 1'b0;
        end
        else if (accept)
        begin
            evict_reg <= (held_reg == swv_pkg::CNT_W'(swv_pkg::WINDOW));
            if (held_reg != swv_pkg::CNT_W'(swv_pkg::WINDOW))
            begin
                held_reg <= held_reg + 1'b1;
            end
            if (slot_reg == swv_pkg::SLOT_W'(swv_pkg::WINDOW - 1))
            begin
                slot_reg <= '0;
            end
            else
            begin
                slot_reg <= slot_reg + 1'b1;
            end
        end
    end

    // reported count, clipped to the field
    always_comb
    begin
        if (int'(held_reg) > swv_pkg::COUNT_MAX)
        begin
            fill_val = swv_pkg::FILL_W'(swv_pkg::COUNT_MAX);
        end
        else
        begin
            fill_val = swv_pkg::FILL_W'(held_reg);
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            for (int c = 0; c < swv_pkg::CHANNELS; c++)
            begin
                var_reg[c] <= lane_var[c];
            end
            fill_reg <= fill_val;
        end
    end

    assign out_valid  = out_valid_reg;
    assign variance_x = var_reg[0];
    assign variance_y = var_reg[1];
    assign variance_z = var_reg[2];
    assign fill_count = fill_reg;

endmodule

// ===== src/swv_div.sv =====
module swv_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [swv_pkg::PROD_W-1:0]   dividend,
    input  logic [swv_pkg::DSOR_W-1:0]   divisor,
    output logic [swv_pkg::PROD_W-1:0]   quotient,
    output logic                         done
);

    logic [swv_pkg::PROD_W-1:0] quo_reg;
    logic [swv_pkg::PROD_W-1:0] quo_next;
    logic [swv_pkg::DSOR_W-1:0] rem_reg;
    logic [swv_pkg::DSOR_W-1:0] rem_next;
    logic [swv_pkg::DSOR_W-1:0] dsor_reg;
    logic [swv_pkg::DCNT_W-1:0] count_reg;
    logic [swv_pkg::DSOR_W:0]   trial;
    logic [swv_pkg::DSOR_W:0]   diff;
    logic                       ge;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, quo_reg[swv_pkg::PROD_W-1]};
        diff     = trial - {1'b0, dsor_reg};
        ge       = (trial >= {1'b0, dsor_reg});
        rem_next = ge ? diff[swv_pkg::DSOR_W-1:0] : trial[swv_pkg::DSOR_W-1:0];
        quo_next = {quo_reg[swv_pkg::PROD_W-2:0], ge};
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (start)
        begin
            count_reg <= swv_pkg::DCNT_W'(swv_pkg::PROD_W);
        end
        else if (count_reg != '0)
        begin
            count_reg <= count_reg - 1'b1;
        end
    end

    // datapath words
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dsor_reg <= divisor;
        end
        else if (count_reg != '0)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = (count_reg == '0);

endmodule

// ===== src/swv_lane.sv =====
module swv_lane
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  swv_pkg::lane_ctl_t         ctl,
    input  logic [swv_pkg::IN_W-1:0]   sample_in,
    output swv_pkg::lane_sts_t         sts,
    output logic [swv_pkg::VAR_W-1:0]  variance
);

    localparam int SB = swv_pkg::SAMPLE_BITS;
    localparam int XW = swv_pkg::SUM_W - SB;
    localparam int PW = 2 * SB;

    swv_pkg::sample_t hist_mem [swv_pkg::WINDOW];
    swv_pkg::sample_t new_reg;
    swv_pkg::sample_t old_reg;

    logic signed [swv_pkg::SUM_W-1:0] sum_reg;
    logic signed [swv_pkg::SUM_W-1:0] sum_next;
    logic signed [swv_pkg::SUM_W-1:0] new_ext;
    logic signed [swv_pkg::SUM_W-1:0] old_ext;
    logic [swv_pkg::SQ_W-1:0]         sumsq_reg;
    logic signed [2*SB-1:0]           sq_new_full;
    logic signed [2*SB-1:0]           sq_old_full;
    logic [2*SB-1:0]                  sq_new_reg;
    logic [2*SB-1:0]                  sq_old_reg;
    logic [swv_pkg::SUM_W-1:0]        mag;
    logic [swv_pkg::NUM_W-1:0]        a_full;
    logic [swv_pkg::SQR_W-1:0]        b_full;
    logic [swv_pkg::DSOR_W-1:0]       dsor_full;
    logic [swv_pkg::PROD_W-1:0]       a_reg;
    logic [swv_pkg::PROD_W-1:0]       b_reg;
    logic [swv_pkg::DSOR_W-1:0]       dsor_reg;
    logic [swv_pkg::PROD_W-1:0]       num;
    logic [swv_pkg::PROD_W-1:0]       quotient;
    logic [swv_pkg::QUO_W-1:0]        quo_ext;
    logic                             div_done;

    // history ring: new word written, evicted word read in the same cycle
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            hist_mem[ctl.slot] <= swv_pkg::sext(sample_in);
            old_reg            <= hist_mem[ctl.slot];
            new_reg            <= swv_pkg::sext(sample_in);
        end
    end

    // running sum update and squares of incoming and evicted samples
    always_comb
    begin
        new_ext     = {{XW{new_reg[SB-1]}}, new_reg};
        old_ext     = {{XW{old_reg[SB-1]}}, old_reg};
        sum_next    = sum_reg + new_ext - (ctl.evict ? old_ext : '0);
        sq_new_full = PW'(new_reg) * PW'(new_reg);
        sq_old_full = PW'(old_reg) * PW'(old_reg);
    end

    // running sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            sumsq_reg <= '0;
        end
        else
        begin
            if (ctl.square)
            begin
                sum_reg <= sum_next;
            end
            if (ctl.sumsq)
            begin
                sumsq_reg <= sumsq_reg + swv_pkg::SQ_W'(sq_new_reg)
                           - swv_pkg::SQ_W'(sq_old_reg);
            end
        end
    end

    // products n*sumsq, sum^2 and n^2
    always_comb
    begin
        mag       = sum_reg[swv_pkg::SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
        a_full    = swv_pkg::NUM_W'(ctl.count) * swv_pkg::NUM_W'(sumsq_reg);
        b_full    = swv_pkg::SQR_W'(mag) * swv_pkg::SQR_W'(mag);
        dsor_full = swv_pkg::DSOR_W'(ctl.count) * swv_pkg::DSOR_W'(ctl.count);
        num       = (a_reg > b_reg) ? (a_reg - b_reg) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.square)
        begin
            sq_new_reg <= sq_new_full;
            sq_old_reg <= ctl.evict ? sq_old_full : '0;
        end
        if (ctl.prod)
        begin
            a_reg    <= swv_pkg::PROD_W'(a_full);
            b_reg    <= swv_pkg::PROD_W'(b_full);
            dsor_reg <= dsor_full;
        end
    end

    // serial divide by n^2
    swv_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.start),
        .dividend (num),
        .divisor  (dsor_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // clip to the result width
    always_comb
    begin
        quo_ext = swv_pkg::QUO_W'(quotient);
        if (quo_ext > swv_pkg::QUO_W'(swv_pkg::VAR_MAX))
        begin
            variance = swv_pkg::VAR_MAX;
        end
        else
        begin
            variance = quo_ext[swv_pkg::VAR_W-1:0];
        end
    end

    assign sts.done = div_done;

endmodule

// ===== src/swv_checker.sv =====
module swv_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic signed [swv_pkg::IN_W-1:0]   sample_x,
    input  logic signed [swv_pkg::IN_W-1:0]   sample_y,
    input  logic signed [swv_pkg::IN_W-1:0]   sample_z,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [swv_pkg::VAR_W-1:0]         variance_x,
    input  logic [swv_pkg::VAR_W-1:0]         variance_y,
    input  logic [swv_pkg::VAR_W-1:0]         variance_z,
    input  logic [swv_pkg::FILL_W-1:0]        fill_count
);

    localparam int FILL_TOP = (swv_pkg::WINDOW > swv_pkg::COUNT_MAX) ?
                              swv_pkg::COUNT_MAX : swv_pkg::WINDOW;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(variance_x)
            && $stable(variance_y) && $stable(variance_z) && $stable(fill_count))
        else $error("stalled result word changed");

    // one word in flight: the input stalls right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after an accept");

    // a delivered count lies between one and the window size, or COUNT_MAX if smaller
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fill_count != '0) && (int'(fill_count) <= FILL_TOP))
        else $error("fill count out of range");

endmodule

bind sliding_window_variance_3ch_top swv_checker u_swv_checker (.*);

// ===== tb/sliding_window_variance_3ch_top_tb.sv =====
`timescale 1ns / 1ps

module sliding_window_variance_3ch_top_tb;

    localparam int  CLK_HALF    = 4;
    localparam int  CYCLE_LIMIT = 500000;
    localparam int  DRAIN_WAIT  = 80;
    localparam longint VAR_CAP  = (64'd1 << swv_pkg::VAR_W) - 1;

    // expected contents of one result word
    typedef struct packed
    {
        logic [swv_pkg::CHANNELS-1:0][swv_pkg::VAR_W-1:0] variance;
        logic [swv_pkg::FILL_W-1:0]                       fill;
    } variance_word_t;

    typedef enum int
    {
        DRAW_UNIFORM,
        DRAW_CLUSTER,
        DRAW_EXTREME
    } draw_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [swv_pkg::IN_W-1:0] sample_x = '0;
    logic signed [swv_pkg::IN_W-1:0] sample_y = '0;
    logic signed [swv_pkg::IN_W-1:0] sample_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [swv_pkg::VAR_W-1:0]  variance_x;
    logic [swv_pkg::VAR_W-1:0]  variance_y;
    logic [swv_pkg::VAR_W-1:0]  variance_z;
    logic [swv_pkg::FILL_W-1:0] fill_count;

    // window model
    longint window_hist [swv_pkg::WINDOW][swv_pkg::CHANNELS];
    longint window_sum [swv_pkg::CHANNELS];
    longint window_sumsq [swv_pkg::CHANNELS];
    int     window_slot = 0;
    int     window_held = 0;

    variance_word_t pending_variances [$];

    bit     sender_idle = 1'b1;
    bit     receiver_idle = 1'b1;
    int     receiver_hold = 0;
    int     error_count = 0;
    int     samples_sent = 0;
    int     words_checked = 0;
    int     cycle_count = 0;
    logic [swv_pkg::IN_W-1:0] cluster_base [swv_pkg::CHANNELS];
    int     cluster_spread = 16;

    sliding_window_variance_3ch_top dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_x   (sample_x),
        .sample_y   (sample_y),
        .sample_z   (sample_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .variance_x (variance_x),
        .variance_y (variance_y),
        .variance_z (variance_z),
        .fill_count (fill_count)
    );

    // clock
    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // run limit
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("%0t: timeout with %0d words outstanding", $time,
                         pending_variances.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // low SAMPLE_BITS of a field as a signed value
    function automatic longint field_to_sample(input logic [swv_pkg::IN_W-1:0] raw);
        longint v;
        longint mask;
        v = 0;
        v[swv_pkg::IN_W-1:0] = raw;
        mask = (64'sd1 <<< swv_pkg::SAMPLE_BITS) - 1;
        v = v & mask;
        if (v[swv_pkg::SAMPLE_BITS-1])
            v = v - (64'sd1 <<< swv_pkg::SAMPLE_BITS);
        return v;
    endfunction

    // floor((n*sumsq - sum^2) / n^2), clipped to the port width
    function automatic logic [swv_pkg::VAR_W-1:0] truncated_variance(input longint sum,
                                                                    input longint sumsq,
                                                                    input longint n);
        longint num;
        longint q;
        num = n * sumsq - sum * sum;
        if (num <= 0)
            return '0;
        q = num / (n * n);
        if (q > VAR_CAP)
            q = VAR_CAP;
        return q[swv_pkg::VAR_W-1:0];
    endfunction

    // push one sample into the window and queue the word it should produce
    task automatic window_push(input logic [swv_pkg::IN_W-1:0] sx,
                               input logic [swv_pkg::IN_W-1:0] sy,
                               input logic [swv_pkg::IN_W-1:0] sz);
        longint         s [swv_pkg::CHANNELS];
        longint         old;
        variance_word_t w;
        s[0] = field_to_sample(sx);
        s[1] = field_to_sample(sy);
        s[2] = field_to_sample(sz);
        for (int c = 0; c < swv_pkg::CHANNELS; c++)
        begin
            if (window_held >= swv_pkg::WINDOW)
            begin
                old = window_hist[window_slot][c];
                window_sum[c]   -= old;
                window_sumsq[c] -= old * old;
            end
            window_hist[window_slot][c] = s[c];
            window_sum[c]   += s[c];
            window_sumsq[c] += s[c] * s[c];
        end
        if (window_held < swv_pkg::WINDOW)
            window_held++;
        window_slot = (window_slot + 1 >= swv_pkg::WINDOW) ? 0 : window_slot + 1;
        for (int c = 0; c < swv_pkg::CHANNELS; c++)
            w.variance[c] = truncated_variance(window_sum[c], window_sumsq[c], window_held);
        w.fill = (window_held > swv_pkg::COUNT_MAX) ? swv_pkg::FILL_W'(swv_pkg::COUNT_MAX)
                                                    : swv_pkg::FILL_W'(window_held);
        pending_variances = {pending_variances, w};
    endtask

    // drive one word and wait for it to be taken
    task automatic send_sample(input logic [swv_pkg::IN_W-1:0] sx,
                               input logic [swv_pkg::IN_W-1:0] sy,
                               input logic [swv_pkg::IN_W-1:0] sz);
        int gap;
        gap = sender_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_x <= sx;
        sample_y <= sy;
        sample_z <= sz;
        do
            @(posedge clk);
        while (in_stall);
        window_push(sx, sy, sz);
        samples_sent++;
    endtask

    function automatic logic [swv_pkg::IN_W-1:0] draw_sample(input draw_mode_t mode,
                                                             input int ch);
        logic [swv_pkg::IN_W-1:0] v;
        case (mode)
            DRAW_CLUSTER:
                v = cluster_base[ch]
                    + swv_pkg::IN_W'($urandom_range(0, 2 * cluster_spread))
                    - swv_pkg::IN_W'(cluster_spread);
            DRAW_EXTREME:
                case ($urandom_range(0, 3))
                    0:       v = {1'b0, {(swv_pkg::IN_W-1){1'b1}}};
                    1:       v = {1'b1, {(swv_pkg::IN_W-1){1'b0}}};
                    2:       v = '0;
                    default: v = '1;
                endcase
            default:
                v = swv_pkg::IN_W'($urandom());
        endcase
        return v;
    endfunction

    // result side: random stall after each word while receiver_idle is set, check against the oldest expectation
    always @(posedge clk)
    begin
        variance_word_t w;
        logic [swv_pkg::VAR_W-1:0] got [swv_pkg::CHANNELS];
        if (rst_n && out_valid && !out_stall)
        begin
            got[0] = variance_x;
            got[1] = variance_y;
            got[2] = variance_z;
            if (pending_variances.size() == 0)
            begin
                $display("%0t: result word with nothing expected (x %0d y %0d z %0d fill %0d)",
                         $time, variance_x, variance_y, variance_z, fill_count);
                error_count++;
            end
            else
            begin
                w = pending_variances[0];
                pending_variances.delete(0);
                for (int c = 0; c < swv_pkg::CHANNELS; c++)
                begin
                    if (got[c] !== w.variance[c])
                    begin
                        $display("%0t: variance ch%0d expected %0d got %0d", $time, c,
                                 w.variance[c], got[c]);
                        error_count++;
                    end
                end
                if (fill_count !== w.fill)
                begin
                    $display("%0t: fill_count expected %0d got %0d", $time, w.fill,
                             fill_count);
                    error_count++;
                end
            end
            words_checked++;
            receiver_hold = receiver_idle ? $urandom_range(0, 9) : 0;
        end
        else if (receiver_hold > 0)
        begin
            receiver_hold--;
        end
        out_stall <= (receiver_hold > 0);
    end

    // window fills with opposing extremes, then wraps
    task automatic test_fill_with_extremes();
        logic [swv_pkg::IN_W-1:0] hi;
        logic [swv_pkg::IN_W-1:0] lo;
        hi = {1'b0, {(swv_pkg::IN_W-1){1'b1}}};
        lo = {1'b1, {(swv_pkg::IN_W-1){1'b0}}};
        for (int i = 0; i < swv_pkg::WINDOW + 2; i++)
        begin
            if (i[0])
                send_sample(hi, lo, swv_pkg::IN_W'(1));
            else
                send_sample(lo, hi, '1);
        end
    endtask

    // a full window of one value should bring every variance back to zero
    task automatic test_constant_window();
        for (int i = 0; i < swv_pkg::WINDOW + 1; i++)
            send_sample({1'b1, {(swv_pkg::IN_W-1){1'b0}}},
                        {1'b0, {(swv_pkg::IN_W-1){1'b1}}},
                        {(swv_pkg::IN_W/2){2'b01}});
    endtask

    task automatic test_random_uniform(input int count);
        for (int i = 0; i < count; i++)
            send_sample(draw_sample(DRAW_UNIFORM, 0), draw_sample(DRAW_UNIFORM, 1),
                        draw_sample(DRAW_UNIFORM, 2));
    endtask

    // clustered signals around a random base with narrow or wide spread
    task automatic test_random_cluster(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
            begin
                for (int c = 0; c < swv_pkg::CHANNELS; c++)
                    cluster_base[c] = swv_pkg::IN_W'($urandom());
                cluster_spread = $urandom_range(0, 1) ? $urandom_range(0, 8)
                                                      : $urandom_range(100, 4000);
            end
            send_sample(draw_sample(DRAW_CLUSTER, 0), draw_sample(DRAW_CLUSTER, 1),
                        draw_sample(DRAW_CLUSTER, 2));
        end
    endtask

    task automatic test_random_extremes(input int count);
        for (int i = 0; i < count; i++)
            send_sample(draw_sample(DRAW_EXTREME, 0), draw_sample(DRAW_EXTREME, 1),
                        draw_sample(DRAW_EXTREME, 2));
    endtask

    // main sequence
    initial
    begin
        for (int r = 0; r < swv_pkg::WINDOW; r++)
            for (int c = 0; c < swv_pkg::CHANNELS; c++)
                window_hist[r][c] = 0;
        for (int c = 0; c < swv_pkg::CHANNELS; c++)
        begin
            window_sum[c]   = 0;
            window_sumsq[c] = 0;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_with_extremes();
        test_constant_window();

        test_random_uniform(400);
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        test_random_uniform(200);
        sender_idle   = 1'b1;
        test_random_cluster(200);
        receiver_idle = 1'b1;
        test_random_cluster(200);
        sender_idle   = 1'b0;
        test_random_extremes(100);
        sender_idle   = 1'b1;
        test_random_extremes(100);
        in_valid <= 1'b0;

        while (pending_variances.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("sent %0d three-channel samples through a %0d-deep window, %0d words checked",
                 samples_sent, swv_pkg::WINDOW, words_checked);
        $display("stimulus: fill and wrap with extremes, constant window, uniform, clustered");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sliding_window_variance_3ch_top.f =====
src/swv_pkg.sv
src/swv_div.sv
src/swv_lane.sv
src/sliding_window_variance_3ch_top.sv
src/swv_checker.sv
tb/sliding_window_variance_3ch_top_tb.sv
